[rtl/warning_overlay_animation_fsm_assert.svh]
// Assertion macros for the warning overlay block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef WARNING_OVERLAY_ANIMATION_FSM_ASSERT_SVH
`define WARNING_OVERLAY_ANIMATION_FSM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define WOA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/woa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// woa_pkg
// Types, codes and constants shared by the warning overlay controller and
// datapath.
// ----------------------------------------------------------------------------
package woa_pkg;

  // Operation codes carried by a beat on the input channel
  typedef enum logic [1:0] {
    FN_SHOW   = 2'd0,
    FN_CLOSE  = 2'd1,
    FN_BUTTON = 2'd2,
    FN_TICK   = 2'd3
  } func_t;

  // Overlay phases
  localparam logic [1:0] PH_BLINK = 2'd0;
  localparam logic [1:0] PH_TRANS = 2'd1;
  localparam logic [1:0] PH_TEXT  = 2'd2;

  // Button codes
  localparam logic [1:0] BTN_PRESS   = 2'd1;
  localparam logic [1:0] BTN_IGNORED = 2'd3;

  // Geometry and timing
  localparam logic [8:0] FULL_SIZE   = 9'd432;
  localparam logic [6:0] SIZE_SHRINK = 7'd96;
  localparam logic [4:0] FULL_Y      = 5'd24;
  localparam logic [4:0] Y_RISE      = 5'd18;
  localparam logic [8:0] TRANS_MS    = 9'd400;
  localparam logic [8:0] BLINK_HALF  = 9'd500;
  localparam logic [9:0] MS_PER_SEC  = 10'd1000;
  localparam logic [7:0] OPAQUE      = 8'd255;
  localparam logic [5:0] MAX_SECONDS = 6'd30;

  // Opacity toggles every half second: floor(2*e/1000) odd means dark
  localparam int unsigned OPAC_SCALE = MS_PER_SEC / BLINK_HALF;

  // Transition progress d*1000/400 reduces to d*5/2
  localparam int unsigned T_NUM   = 5;
  localparam int unsigned T_SHIFT = 1;

  // Divide by 1000: q = (a * ceil(2^32/1000)) >> 32 is exact for a < 2^22
  localparam int unsigned DIV_IN_W  = 22;
  localparam int unsigned DIV_K_W   = 23;
  localparam int unsigned DIV_SHIFT = 32;
  localparam int unsigned PROD_W    = DIV_IN_W + DIV_K_W;
  localparam logic [DIV_K_W-1:0] DIV_K = 23'd4294968;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXEC,
    OP_DIV,
    OP_OPAC,
    OP_EASE,
    OP_SIZE_MUL,
    OP_Y_MUL,
    OP_Y,
    OP_PUB
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } woa_cmd_t;

  typedef struct packed {
    logic anim;
  } woa_sts_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_OPAC,
    ST_OPAC,
    ST_DIV_SQ,
    ST_EASE,
    ST_DIV_EASE,
    ST_SIZE_MUL,
    ST_DIV_SIZE,
    ST_Y_MUL,
    ST_DIV_Y,
    ST_Y,
    ST_PUB
  } woa_state_t;

endpackage
`default_nettype wire

[rtl/woa_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// woa_dp
// Overlay state, operation decode and the shared divide-by-1000 unit that
// evaluates the opacity blink and the smoothstep easing step by step.
// ----------------------------------------------------------------------------
module woa_dp
  import woa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire woa_cmd_t    cmd,
  output woa_sts_t         sts,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_icon_code,
  input  wire logic [23:0] in_color_code,
  input  wire logic [15:0] in_message_id,
  input  wire logic [5:0]  in_blink_seconds,
  input  wire logic [5:0]  in_text_seconds,
  input  wire logic [1:0]  in_button_index,
  input  wire logic [1:0]  in_button_event,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        in_display_allowed,
  output logic             out_overlay_active,
  output logic [1:0]       out_overlay_phase,
  output logic [7:0]       out_overlay_opacity,
  output logic [8:0]       out_overlay_size,
  output logic [4:0]       out_overlay_y,
  output logic [15:0]      out_shown_icon,
  output logic [23:0]      out_shown_color,
  output logic [15:0]      out_shown_message,
  output logic             out_button_consumed
);

  // Captured beat
  func_t       func_r;
  logic [15:0] icon_in_r;
  logic [23:0] color_in_r;
  logic [15:0] msg_in_r;
  logic [5:0]  bsec_r;
  logic [5:0]  tsec_r;
  logic [1:0]  bidx_r;
  logic [1:0]  bevt_r;
  logic [31:0] now_r;
  logic        allowed_r;

  // Architectural state
  logic        active_r, active_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  opacity_r, opacity_nxt;
  logic [8:0]  size_r, size_nxt;
  logic [4:0]  ypos_r, ypos_nxt;
  logic [15:0] icon_r, icon_nxt;
  logic [23:0] color_r, color_nxt;
  logic [15:0] message_r, message_nxt;
  logic [31:0] start_r, start_nxt;
  logic [14:0] blink_len_r, blink_len_nxt;
  logic [14:0] text_len_r, text_len_nxt;
  logic [31:0] last_now_r, last_now_nxt;
  logic [2:0]  quar_r, quar_nxt;

  // Working registers
  logic [9:0]          t_r, t_nxt;
  logic [9:0]          ease_r, ease_nxt;
  logic [DIV_IN_W-1:0] mul_r, mul_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic                consumed_r, consumed_nxt;

  // Result register
  logic        out_active_r;
  logic [1:0]  out_phase_r;
  logic [7:0]  out_opacity_r;
  logic [8:0]  out_size_r;
  logic [4:0]  out_y_r;
  logic [15:0] out_icon_r;
  logic [23:0] out_color_r;
  logic [15:0] out_message_r;
  logic        out_consumed_r;

  // Tick timing
  logic [31:0] el32;
  logic [15:0] el;
  logic [15:0] blink_end;
  logic [15:0] trans_end;
  logic [15:0] total;
  logic        expired;
  logic [15:0] d;
  logic [9:0]  t_trans;
  logic [12:0] quot;
  logic [11:0] ease_w;

  // Show and button decode
  logic        show_ok;
  logic        same_warning;
  logic [2:0]  bit_m;
  logic        quar_hit;
  logic        press;

  assign el32      = now_r - start_r;
  assign el        = el32[15:0];
  assign blink_end = {1'b0, blink_len_r};
  assign trans_end = blink_end + 16'(TRANS_MS);
  assign total     = trans_end + {1'b0, text_len_r};
  assign expired   = (el32 >= {16'd0, total});
  assign d         = el - blink_end;
  assign t_trans   = 10'((11'(d[8:0]) * 11'(T_NUM)) >> T_SHIFT);
  assign quot      = prod_r[PROD_W-1:DIV_SHIFT];
  assign ease_w    = 12'(3 * MS_PER_SEC) - (12'(t_r) << 1);

  assign show_ok      = (bsec_r <= MAX_SECONDS) && (tsec_r <= MAX_SECONDS);
  assign same_warning = active_r && (icon_r == icon_in_r) && (color_r == color_in_r) &&
                        (message_r == msg_in_r);
  assign bit_m        = 3'b001 << bidx_r;
  assign quar_hit     = |(quar_r & bit_m);
  assign press        = (bevt_r == BTN_PRESS);

  assign sts.anim = (func_r == FN_TICK) && allowed_r && active_r && !expired;

  // Next-state logic for each datapath operation
  always_comb begin
    active_nxt    = active_r;
    phase_nxt     = phase_r;
    opacity_nxt   = opacity_r;
    size_nxt      = size_r;
    ypos_nxt      = ypos_r;
    icon_nxt      = icon_r;
    color_nxt     = color_r;
    message_nxt   = message_r;
    start_nxt     = start_r;
    blink_len_nxt = blink_len_r;
    text_len_nxt  = text_len_r;
    last_now_nxt  = last_now_r;
    quar_nxt      = quar_r;
    t_nxt         = t_r;
    ease_nxt      = ease_r;
    mul_nxt       = mul_r;
    prod_nxt      = prod_r;
    consumed_nxt  = consumed_r;
    case (cmd.op)
      OP_EXEC: begin
        consumed_nxt = 1'b0;
        case (func_r)
          FN_SHOW: begin
            if (show_ok && !same_warning) begin
              active_nxt    = 1'b1;
              phase_nxt     = PH_BLINK;
              opacity_nxt   = OPAQUE;
              size_nxt      = FULL_SIZE;
              ypos_nxt      = FULL_Y;
              icon_nxt      = icon_in_r;
              color_nxt     = color_in_r;
              message_nxt   = msg_in_r;
              start_nxt     = last_now_r;
              blink_len_nxt = 15'(bsec_r) * 15'(MS_PER_SEC);
              text_len_nxt  = 15'(tsec_r) * 15'(MS_PER_SEC);
            end
          end
          FN_CLOSE: begin
            active_nxt = 1'b0;
          end
          FN_BUTTON: begin
            if (bidx_r != BTN_IGNORED) begin
              if (quar_hit && !press) begin
                consumed_nxt = 1'b1;
              end else if (active_r) begin
                // event on an active overlay: swallow it, and quarantine a press
                consumed_nxt = 1'b1;
                if (press) begin
                  quar_nxt = quar_r | bit_m;
                  if (phase_r == PH_TEXT) begin
                    active_nxt = 1'b0;
                  end
                end
              end else begin
                // lift quarantine on press; the event is not consumed
                quar_nxt = quar_r & ~bit_m;
              end
            end
          end
          default: begin
            last_now_nxt = now_r;
            if (!allowed_r) begin
              active_nxt = 1'b0;
            end else if (active_r) begin
              if (expired) begin
                active_nxt = 1'b0;
              end else begin
                if (el < blink_end) begin
                  phase_nxt = PH_BLINK;
                  t_nxt     = 10'd0;
                end else if (el < trans_end) begin
                  phase_nxt = PH_TRANS;
                  t_nxt     = t_trans;
                end else begin
                  phase_nxt = PH_TEXT;
                  t_nxt     = MS_PER_SEC;
                end
                mul_nxt = DIV_IN_W'(el) * DIV_IN_W'(OPAC_SCALE);
              end
            end
          end
        endcase
      end
      OP_DIV: begin
        prod_nxt = PROD_W'(mul_r) * PROD_W'(DIV_K);
      end
      OP_OPAC: begin
        opacity_nxt = ((phase_r == PH_BLINK) && quot[0]) ? 8'd0 : OPAQUE;
        mul_nxt     = DIV_IN_W'(t_r) * DIV_IN_W'(t_r);
      end
      OP_EASE: begin
        mul_nxt = DIV_IN_W'(quot[9:0]) * DIV_IN_W'(ease_w);
      end
      OP_SIZE_MUL: begin
        ease_nxt = quot[9:0];
        mul_nxt  = DIV_IN_W'(quot[9:0]) * DIV_IN_W'(SIZE_SHRINK);
      end
      OP_Y_MUL: begin
        size_nxt = FULL_SIZE - quot[8:0];
        mul_nxt  = DIV_IN_W'(ease_r) * DIV_IN_W'(Y_RISE);
      end
      OP_Y: begin
        ypos_nxt = FULL_Y - quot[4:0];
      end
      default: begin
      end
    endcase
  end

  // Architectural state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      phase_r     <= 2'd0;
      opacity_r   <= 8'd0;
      size_r      <= 9'd0;
      ypos_r      <= 5'd0;
      icon_r      <= 16'd0;
      color_r     <= 24'd0;
      message_r   <= 16'd0;
      start_r     <= 32'd0;
      blink_len_r <= 15'd0;
      text_len_r  <= 15'd0;
      last_now_r  <= 32'd0;
      quar_r      <= 3'd0;
    end else begin
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      opacity_r   <= opacity_nxt;
      size_r      <= size_nxt;
      ypos_r      <= ypos_nxt;
      icon_r      <= icon_nxt;
      color_r     <= color_nxt;
      message_r   <= message_nxt;
      start_r     <= start_nxt;
      blink_len_r <= blink_len_nxt;
      text_len_r  <= text_len_nxt;
      last_now_r  <= last_now_nxt;
      quar_r      <= quar_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    ease_r     <= ease_nxt;
    mul_r      <= mul_nxt;
    prod_r     <= prod_nxt;
    consumed_r <= consumed_nxt;
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      func_r     <= func_t'(in_func);
      icon_in_r  <= in_icon_code;
      color_in_r <= in_color_code;
      msg_in_r   <= in_message_id;
      bsec_r     <= in_blink_seconds;
      tsec_r     <= in_text_seconds;
      bidx_r     <= in_button_index;
      bevt_r     <= in_button_event;
      now_r      <= in_now_ms;
      allowed_r  <= in_display_allowed;
    end
  end

  // Publish the result beat
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUB) begin
      out_active_r   <= active_r;
      out_phase_r    <= phase_r;
      out_opacity_r  <= opacity_r;
      out_size_r     <= size_r;
      out_y_r        <= ypos_r;
      out_icon_r     <= icon_r;
      out_color_r    <= color_r;
      out_message_r  <= message_r;
      out_consumed_r <= consumed_r;
    end
  end

  assign out_overlay_active  = out_active_r;
  assign out_overlay_phase   = out_phase_r;
  assign out_overlay_opacity = out_opacity_r;
  assign out_overlay_size    = out_size_r;
  assign out_overlay_y       = out_y_r;
  assign out_shown_icon      = out_icon_r;
  assign out_shown_color     = out_color_r;
  assign out_shown_message   = out_message_r;
  assign out_button_consumed = out_consumed_r;

endmodule
`default_nettype wire

[rtl/woa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "warning_overlay_animation_fsm_assert.svh"
// ----------------------------------------------------------------------------
// woa_ctrl
// Sequencer for the warning overlay: takes a beat, runs the execute step,
// steps the easing sequence on animated ticks and hands off the result.
// ----------------------------------------------------------------------------
module woa_ctrl
  import woa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire woa_sts_t sts,
  output woa_cmd_t      cmd
);

  woa_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.op    = OP_EXEC;
        state_nxt = sts.anim ? ST_DIV_OPAC : ST_PUB;
      end
      ST_DIV_OPAC: begin
        cmd.op    = OP_DIV;
        state_nxt = ST_OPAC;
      end
      ST_OPAC: begin
        cmd.op    = OP_OPAC;
        state_nxt = ST_DIV_SQ;
      end
      ST_DIV_SQ: begin
        cmd.op    = OP_DIV;
        state_nxt = ST_EASE;
      end
      ST_EASE: begin
        cmd.op    = OP_EASE;
        state_nxt = ST_DIV_EASE;
      end
      ST_DIV_EASE: begin
        cmd.op    = OP_DIV;
        state_nxt = ST_SIZE_MUL;
      end
      ST_SIZE_MUL: begin
        cmd.op    = OP_SIZE_MUL;
        state_nxt = ST_DIV_SIZE;
      end
      ST_DIV_SIZE: begin
        cmd.op    = OP_DIV;
        state_nxt = ST_Y_MUL;
      end
      ST_Y_MUL: begin
        cmd.op    = OP_Y_MUL;
        state_nxt = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        cmd.op    = OP_DIV;
        state_nxt = ST_Y;
      end
      ST_Y: begin
        cmd.op    = OP_Y;
        state_nxt = ST_PUB;
      end
      ST_PUB: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_PUB;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Checks on sequencing
  `WOA_ASSERT_NEXT(a_accept_exec, rst_n && in_valid && !in_stall, state_r == ST_EXEC,
                   "accepted beat not followed by execute step")
  `WOA_ASSERT_SAME(a_pub_free, cmd.op == OP_PUB, !out_valid_r || !out_stall,
                   "result published over a waiting beat")
  `WOA_ASSERT_NEXT(a_pub_valid, rst_n && (cmd.op == OP_PUB),
                   out_valid_r && (state_r == ST_IDLE),
                   "publish did not raise result valid")
  `WOA_ASSERT_NEXT(a_plain_pub, rst_n && (state_r == ST_EXEC) && !sts.anim,
                   state_r == ST_PUB, "non-animated beat did not go to publish")

endmodule
`default_nettype wire

[rtl/warning_overlay_animation_fsm.sv]
`timescale 1ns / 1ps
`default_nettype none
// Warning overlay controller. A beat on the input channel is a show, close,
// button or tick operation; every beat yields exactly one result beat with
// the overlay state after the update. Show, close, button and non-animating
// ticks pass from acceptance through the execute and publish states back
// to idle. A tick that keeps the overlay shown also runs the opacity blink
// and the smoothstep easing through a single shared divide-by-1000 unit
// (reciprocal multiply, five divides) interleaved with one constant or
// small multiply per step. A new beat is accepted while the previous
// result still waits on out_stall.
// ----------------------------------------------------------------------------
// warning_overlay_animation_fsm
// Top level: controller and datapath of the timed warning overlay.
// ----------------------------------------------------------------------------
module warning_overlay_animation_fsm
  import woa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_icon_code,
  input  wire logic [23:0] in_color_code,
  input  wire logic [15:0] in_message_id,
  input  wire logic [5:0]  in_blink_seconds,
  input  wire logic [5:0]  in_text_seconds,
  input  wire logic [1:0]  in_button_index,
  input  wire logic [1:0]  in_button_event,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        in_display_allowed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_overlay_active,
  output logic [1:0]       out_overlay_phase,
  output logic [7:0]       out_overlay_opacity,
  output logic [8:0]       out_overlay_size,
  output logic [4:0]       out_overlay_y,
  output logic [15:0]      out_shown_icon,
  output logic [23:0]      out_shown_color,
  output logic [15:0]      out_shown_message,
  output logic             out_button_consumed
);

  woa_cmd_t cmd;
  woa_sts_t sts;

  // Sequencer
  woa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // State and arithmetic
  woa_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_func),
    .in_icon_code        (in_icon_code),
    .in_color_code       (in_color_code),
    .in_message_id       (in_message_id),
    .in_blink_seconds    (in_blink_seconds),
    .in_text_seconds     (in_text_seconds),
    .in_button_index     (in_button_index),
    .in_button_event     (in_button_event),
    .in_now_ms           (in_now_ms),
    .in_display_allowed  (in_display_allowed),
    .out_overlay_active  (out_overlay_active),
    .out_overlay_phase   (out_overlay_phase),
    .out_overlay_opacity (out_overlay_opacity),
    .out_overlay_size    (out_overlay_size),
    .out_overlay_y       (out_overlay_y),
    .out_shown_icon      (out_shown_icon),
    .out_shown_color     (out_shown_color),
    .out_shown_message   (out_shown_message),
    .out_button_consumed (out_button_consumed)
  );

endmodule
`default_nettype wire

[tb/sv/warning_overlay_animation_fsm_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// warning_overlay_animation_fsm_tb
// Self-checking bench for the warning overlay controller. Show, close, button
// and tick beats are pushed under random sender gaps and receiver stalls, and
// every result beat is compared field by field with an in-bench model of the
// overlay timing, easing and button quarantine.
// ----------------------------------------------------------------------------
module warning_overlay_animation_fsm_tb;
  import woa_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned BEATS_PER_PHASE = 350;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned DRAIN_CYCLES    = 24;

  // Model constants widened to the 32-bit working width
  localparam bit [31:0] MS_1S      = 32'(MS_PER_SEC);
  localparam bit [31:0] TRANS_SPAN = 32'(TRANS_MS);
  localparam bit [31:0] HALF_SPAN  = 32'(BLINK_HALF);
  localparam bit [31:0] SHRINK_PX  = 32'(SIZE_SHRINK);
  localparam bit [31:0] RISE_PX    = 32'(Y_RISE);
  localparam bit [31:0] FULL_PX    = 32'(FULL_SIZE);
  localparam bit [31:0] FULL_YPX   = 32'(FULL_Y);

  typedef struct {
    func_t     func;
    bit [15:0] icon;
    bit [23:0] color;
    bit [15:0] message;
    bit [5:0]  blink_s;
    bit [5:0]  text_s;
    bit [1:0]  button_index;
    bit [1:0]  button_event;
    bit [31:0] now_ms;
    bit        display_allowed;
  } overlay_beat_t;

  typedef struct {
    bit        active;
    bit [1:0]  phase;
    bit [7:0]  opacity;
    bit [8:0]  size_px;
    bit [4:0]  y_px;
    bit [15:0] icon;
    bit [23:0] color;
    bit [15:0] message;
    bit        consumed;
  } overlay_result_t;

  // Overlay model and queue of expected result beats
  class overlay_scoreboard;
    bit        shown;
    bit [1:0]  phase;
    bit [7:0]  opacity;
    bit [8:0]  size_px;
    bit [4:0]  y_px;
    bit [15:0] icon;
    bit [23:0] color;
    bit [15:0] message;
    bit [31:0] anchor_ms;
    bit [14:0] blink_span;
    bit [14:0] text_ms;
    bit [31:0] latest_ms;
    bit [2:0]  held_buttons;
    overlay_result_t expected_overlays[$];
    int unsigned mismatches;

    // Apply one accepted beat to the model and queue the overlay it leaves
    function void note_beat(overlay_beat_t b);
      overlay_result_t want;
      bit [2:0]  mask;
      bit [31:0] elapsed;
      bit [31:0] blink_end;
      bit [31:0] trans_end;
      bit [31:0] life_end;
      bit [31:0] progress;
      bit [31:0] ease;
      bit        consumed;
      consumed = 1'b0;
      case (b.func)
        FN_SHOW: begin
          // drop over-long durations and a re-show of the warning on screen
          if (b.blink_s <= MAX_SECONDS && b.text_s <= MAX_SECONDS &&
              !(shown && icon == b.icon && color == b.color && message == b.message)) begin
            shown      = 1'b1;
            phase      = PH_BLINK;
            opacity    = OPAQUE;
            size_px    = FULL_SIZE;
            y_px       = FULL_Y;
            icon       = b.icon;
            color      = b.color;
            message    = b.message;
            anchor_ms  = latest_ms;
            blink_span = 15'(b.blink_s) * 15'(MS_PER_SEC);
            text_ms    = 15'(b.text_s) * 15'(MS_PER_SEC);
          end
        end
        FN_CLOSE: begin
          shown = 1'b0;
        end
        FN_BUTTON: begin
          if (b.button_index != BTN_IGNORED) begin
            mask = 3'b001 << b.button_index;
            if ((held_buttons & mask) != 3'b000 && b.button_event != BTN_PRESS) begin
              consumed = 1'b1;
            end else begin
              // a press lifts the quarantine, then counts as a normal press
              held_buttons = held_buttons & ~mask;
              if (shown) begin
                consumed = 1'b1;
                if (b.button_event == BTN_PRESS) begin
                  held_buttons = held_buttons | mask;
                  if (phase == PH_TEXT) shown = 1'b0;
                end
              end
            end
          end
        end
        default: begin
          latest_ms = b.now_ms;
          if (!b.display_allowed) begin
            shown = 1'b0;
          end else if (shown) begin
            elapsed   = b.now_ms - anchor_ms;
            blink_end = 32'(blink_span);
            trans_end = blink_end + TRANS_SPAN;
            life_end  = trans_end + 32'(text_ms);
            if (elapsed >= life_end) begin
              shown = 1'b0;
            end else begin
              if (elapsed < blink_end) phase = PH_BLINK;
              else if (elapsed < trans_end) phase = PH_TRANS;
              else phase = PH_TEXT;
              if (phase == PH_BLINK) begin
                opacity = (elapsed % MS_1S < HALF_SPAN) ? OPAQUE : 8'd0;
              end else begin
                opacity = OPAQUE;
              end
              // smoothstep on a 0..1000 scale
              case (phase)
                PH_BLINK: progress = 32'd0;
                PH_TEXT:  progress = MS_1S;
                default:  progress = (elapsed - blink_end) * MS_1S / TRANS_SPAN;
              endcase
              ease = progress * progress / MS_1S * (32'd3 * MS_1S - 32'd2 * progress)
                     / MS_1S;
              size_px = 9'(FULL_PX - SHRINK_PX * ease / MS_1S);
              y_px    = 5'(FULL_YPX - RISE_PX * ease / MS_1S);
            end
          end
        end
      endcase
      want.active   = shown;
      want.phase    = phase;
      want.opacity  = opacity;
      want.size_px  = size_px;
      want.y_px     = y_px;
      want.icon     = icon;
      want.color    = color;
      want.message  = message;
      want.consumed = consumed;
      expected_overlays.push_back(want);
    endfunction

    function void compare_field(string field, bit [31:0] want, bit [31:0] got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
      end
    endfunction

    // Check one accepted result beat against the oldest expectation
    function void check_overlay(overlay_result_t got);
      overlay_result_t want;
      if (expected_overlays.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with no expectation pending", $realtime);
        return;
      end
      want = expected_overlays.pop_front();
      compare_field("overlay_active",  32'(want.active),   32'(got.active));
      compare_field("overlay_phase",   32'(want.phase),    32'(got.phase));
      compare_field("overlay_opacity", 32'(want.opacity),  32'(got.opacity));
      compare_field("overlay_size",    32'(want.size_px),  32'(got.size_px));
      compare_field("overlay_y",       32'(want.y_px),     32'(got.y_px));
      compare_field("shown_icon",      32'(want.icon),     32'(got.icon));
      compare_field("shown_color",     32'(want.color),    32'(got.color));
      compare_field("shown_message",   32'(want.message),  32'(got.message));
      compare_field("button_consumed", 32'(want.consumed), 32'(got.consumed));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FN_CLOSE;
  logic [15:0] in_icon_code = '0;
  logic [23:0] in_color_code = '0;
  logic [15:0] in_message_id = '0;
  logic [5:0]  in_blink_seconds = '0;
  logic [5:0]  in_text_seconds = '0;
  logic [1:0]  in_button_index = '0;
  logic [1:0]  in_button_event = '0;
  logic [31:0] in_now_ms = '0;
  logic        in_display_allowed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_overlay_active;
  logic [1:0]  out_overlay_phase;
  logic [7:0]  out_overlay_opacity;
  logic [8:0]  out_overlay_size;
  logic [4:0]  out_overlay_y;
  logic [15:0] out_shown_icon;
  logic [23:0] out_shown_color;
  logic [15:0] out_shown_message;
  logic        out_button_consumed;

  overlay_scoreboard sb = new();

  int unsigned send_idle_pct = 27;
  int unsigned recv_stall_pct = 53;
  int unsigned counted = 0;
  int unsigned cycle_count = 0;
  bit [31:0]   clock_ms = '0;
  bit [15:0]   last_icon = '0;
  bit [23:0]   last_color = '0;
  bit [15:0]   last_message = '0;

  warning_overlay_animation_fsm u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_icon_code       (in_icon_code),
    .in_color_code      (in_color_code),
    .in_message_id      (in_message_id),
    .in_blink_seconds   (in_blink_seconds),
    .in_text_seconds    (in_text_seconds),
    .in_button_index    (in_button_index),
    .in_button_event    (in_button_event),
    .in_now_ms          (in_now_ms),
    .in_display_allowed (in_display_allowed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_overlay_active (out_overlay_active),
    .out_overlay_phase  (out_overlay_phase),
    .out_overlay_opacity(out_overlay_opacity),
    .out_overlay_size   (out_overlay_size),
    .out_overlay_y      (out_overlay_y),
    .out_shown_icon     (out_shown_icon),
    .out_shown_color    (out_shown_color),
    .out_shown_message  (out_shown_message),
    .out_button_consumed(out_button_consumed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Check result beats and drive random stalls on the result channel
  always @(posedge clk) begin : result_monitor
    overlay_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.active   = out_overlay_active;
      got.phase    = out_overlay_phase;
      got.opacity  = out_overlay_opacity;
      got.size_px  = out_overlay_size;
      got.y_px     = out_overlay_y;
      got.icon     = out_shown_icon;
      got.color    = out_shown_color;
      got.message  = out_shown_message;
      got.consumed = out_button_consumed;
      sb.check_overlay(got);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic overlay_beat_t any_beat();
    overlay_beat_t b;
    b.func            = func_t'($urandom_range(3));
    b.icon            = 16'($urandom);
    b.color           = 24'($urandom);
    b.message         = 16'($urandom);
    b.blink_s         = 6'($urandom);
    b.text_s          = 6'($urandom);
    b.button_index    = 2'($urandom);
    b.button_event    = 2'($urandom);
    b.now_ms          = $urandom;
    b.display_allowed = 1'($urandom_range(1));
    return b;
  endfunction

  function automatic overlay_beat_t show_beat(bit [15:0] icon, bit [23:0] color,
                                              bit [15:0] message, bit [5:0] blink_s,
                                              bit [5:0] text_s);
    overlay_beat_t b;
    b         = any_beat();
    b.func    = FN_SHOW;
    b.icon    = icon;
    b.color   = color;
    b.message = message;
    b.blink_s = blink_s;
    b.text_s  = text_s;
    return b;
  endfunction

  function automatic overlay_beat_t tick_beat(bit [31:0] now_ms, bit allowed);
    overlay_beat_t b;
    b                 = any_beat();
    b.func            = FN_TICK;
    b.now_ms          = now_ms;
    b.display_allowed = allowed;
    return b;
  endfunction

  function automatic overlay_beat_t button_beat(bit [1:0] index, bit [1:0] kind);
    overlay_beat_t b;
    b              = any_beat();
    b.func         = FN_BUTTON;
    b.button_index = index;
    b.button_event = kind;
    return b;
  endfunction

  function automatic overlay_beat_t close_beat();
    overlay_beat_t b;
    b      = any_beat();
    b.func = FN_CLOSE;
    return b;
  endfunction

  // Mostly short phases so that whole overlays run out; now and then long or rejected
  function automatic bit [5:0] pick_seconds();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return 6'($urandom_range(1));
    if (r < 93) return 6'($urandom_range(MAX_SECONDS));
    return 6'($urandom_range(63, MAX_SECONDS + 1));
  endfunction

  // Push one beat through the input handshake and note it on acceptance
  task automatic drive_beat(input overlay_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_func            <= b.func;
    in_icon_code       <= b.icon;
    in_color_code      <= b.color;
    in_message_id      <= b.message;
    in_blink_seconds   <= b.blink_s;
    in_text_seconds    <= b.text_s;
    in_button_index    <= b.button_index;
    in_button_event    <= b.button_event;
    in_now_ms          <= b.now_ms;
    in_display_allowed <= b.display_allowed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(b);
    if (b.func == FN_TICK) clock_ms = b.now_ms;
    if (b.func == FN_SHOW) begin
      last_icon    = b.icon;
      last_color   = b.color;
      last_message = b.message;
    end
    counted++;
  endtask

  task automatic run_directed();
    drive_beat(tick_beat(32'd0, 1'b1));
    drive_beat(button_beat(BTN_IGNORED, BTN_PRESS));
    drive_beat(button_beat(2'd0, BTN_PRESS));
    // over-long blink, then over-long text
    drive_beat(show_beat(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 6'(MAX_SECONDS + 1), 6'd0));
    drive_beat(show_beat(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 6'd0, 6'd63));
    // fresh show, then the same warning again
    drive_beat(show_beat(16'h0000, 24'h000000, 16'h0000, 6'd1, 6'd1));
    drive_beat(show_beat(16'h0000, 24'h000000, 16'h0000, 6'd1, 6'd1));
    drive_beat(tick_beat(32'd250, 1'b1));
    drive_beat(tick_beat(32'd600, 1'b1));
    // release, press into quarantine, quarantined long press
    drive_beat(button_beat(2'd1, 2'd0));
    drive_beat(button_beat(2'd1, BTN_PRESS));
    drive_beat(button_beat(2'd1, 2'd2));
    drive_beat(tick_beat(32'd1200, 1'b1));
    drive_beat(tick_beat(32'd1500, 1'b1));
    // press in the text phase closes; the next press only lifts quarantine
    drive_beat(button_beat(2'd1, BTN_PRESS));
    drive_beat(button_beat(2'd1, BTN_PRESS));
    // longest phases across the time wrap
    drive_beat(tick_beat(32'hFFFF_FF00, 1'b1));
    drive_beat(show_beat(16'hFFFF, 24'hFFFFFF, 16'hFFFF, MAX_SECONDS, MAX_SECONDS));
    drive_beat(tick_beat(32'h0000_0100, 1'b1));
    drive_beat(button_beat(2'd2, 2'd3));
    drive_beat(tick_beat(32'h0000_0200, 1'b0));
    // zero-length phases expire at exactly the transition time
    drive_beat(show_beat(16'h1234, 24'hABCDEF, 16'h0001, 6'd0, 6'd0));
    drive_beat(tick_beat(32'h0000_0390, 1'b1));
    drive_beat(show_beat(16'h1234, 24'hABCDEF, 16'h0001, 6'd0, 6'd2));
    drive_beat(close_beat());
  endtask

  // One warning from show to end, with buttons, closes and re-shows between ticks
  task automatic run_episode();
    int unsigned steps;
    int unsigned sel;
    bit [31:0]   step_ms;
    if ($urandom_range(19) == 0)
      drive_beat(tick_beat(32'hFFFF_FFFF - $urandom_range(20000), 1'b1));
    drive_beat(show_beat(16'($urandom), 24'($urandom), 16'($urandom),
                         pick_seconds(), pick_seconds()));
    steps = $urandom_range(30, 8);
    repeat (steps) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        step_ms = ($urandom_range(9) == 0) ? $urandom_range(5000) : $urandom_range(600);
        drive_beat(tick_beat(clock_ms + step_ms, $urandom_range(19) != 0));
      end else if (sel < 82) begin
        drive_beat(button_beat(2'($urandom_range(3)),
                               $urandom_range(1) ? BTN_PRESS : 2'($urandom_range(3))));
      end else if (sel < 88) begin
        drive_beat(show_beat(last_icon, last_color, last_message,
                             6'($urandom_range(3)), 6'($urandom_range(3))));
      end else if (sel < 94) begin
        drive_beat(close_beat());
      end else begin
        drive_beat(show_beat(16'($urandom), 24'($urandom), 16'($urandom),
                             pick_seconds(), pick_seconds()));
      end
    end
  endtask

  task automatic run_random(input int unsigned beats);
    int unsigned goal;
    goal = counted + beats;
    while (counted < goal) begin
      if ($urandom_range(99) < 8) drive_beat(any_beat());
      else run_episode();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(BEATS_PER_PHASE);
    send_idle_pct  = 53;
    recv_stall_pct = 27;
    run_random(BEATS_PER_PHASE);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(BEATS_PER_PHASE);
    in_valid <= 1'b0;
    // drain outstanding results, then allow for any stray beat
    while (sb.expected_overlays.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_overlays.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
